// File: rtl/picc_pkg.sv
// ----------------------------------------------------------------------------
// picc_pkg: shared types and constants for the particle integrate block
// Fixed point format, register indexes, pipeline stage map and the
// rounding and saturation helpers.
// ----------------------------------------------------------------------------
package picc_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic signed [43:0] HALF_FX = 44'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [21:0] ONE_FX  = 22'sd1 <<< FRAC_BITS;
    localparam logic signed [21:0] HALF_P  = 22'sd1 <<< (FRAC_BITS - 1);

    // register indexes
    localparam logic [2:0] REG_ACCEL_X     = 3'd0;
    localparam logic [2:0] REG_ACCEL_Y     = 3'd1;
    localparam logic [2:0] REG_TIME_STEP   = 3'd2;
    localparam logic [2:0] REG_RESTITUTION = 3'd3;
    localparam logic [2:0] REG_TANGENT     = 3'd4;
    localparam logic [2:0] REG_PART_RAD    = 3'd5;
    localparam logic [2:0] REG_CONT_RAD    = 3'd6;

    localparam logic [15:0] TIME_STEP_RST   = 16'd1092;
    localparam logic [16:0] RESTITUTION_RST = 17'd32768;
    localparam logic [16:0] TANGENT_RST     = 17'd65536;
    localparam logic [15:0] PART_RAD_RST    = 16'd655;
    localparam logic [15:0] CONT_RAD_RST    = 16'd29491;
    localparam logic [31:0] CONT_SQ_RST     = 32'd869719081;

    // stage map: front end, root stages, divide stages, wall response
    localparam int SQ_STEPS = 16;
    localparam int DV_STEPS = 17;
    localparam int SQ0      = 8;
    localparam int DV0      = SQ0 + SQ_STEPS;
    localparam int B1       = DV0 + DV_STEPS;
    localparam int N_STG    = B1 + 8;

    typedef struct packed {
        logic               last;
        logic               hit;
        logic signed [21:0] px;
        logic signed [21:0] py;
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic signed [43:0] ma;
        logic signed [43:0] mb;
        logic signed [43:0] mc;
        logic signed [43:0] md;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] pen;
        logic [31:0]        d2;
        logic [18:0]        srem;
        logic [15:0]        root;
        logic [31:0]        ax_div;
        logic [31:0]        ay_div;
        logic [16:0]        remx;
        logic [16:0]        remy;
        logic [16:0]        qx;
        logic [16:0]        qy;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [21:0] vn;
        logic signed [22:0] vxn;
        logic signed [22:0] vyn;
        logic signed [22:0] vxt;
        logic signed [22:0] vyt;
    } item_t;

    // round to nearest, ties toward plus infinity
    function automatic logic signed [43:0] rescale(input logic signed [43:0] v);
        return (v + HALF_FX) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [43:0] v);
        logic signed [19:0] r;
        if (v > 44'sd524287)
            r = 20'sh7FFFF;
        else if (v < -44'sd524288)
            r = 20'sh80000;
        else
            r = v[19:0];
        return r;
    endfunction

endpackage

// File: rtl/particle_integrate_circle_collide.sv
// ----------------------------------------------------------------------------
// particle_integrate_circle_collide
// One particle step: Euler update, box clamp and circular wall response.
// ----------------------------------------------------------------------------
// Pipeline: 49 register stages (8 front, 16 square root, 17 divide,
//   8 wall response).
// Throughput: one item per cycle; the whole pipe holds while the output
//   stage is full and not taken.
// Reset: valid bits clear, configuration registers return to their documented defaults.
module particle_integrate_circle_collide
    import picc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_addr,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [19:0] pos_x,
    input  logic signed [19:0] pos_y,
    input  logic signed [19:0] vel_x,
    input  logic signed [19:0] vel_y,
    input  logic               last_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] new_pos_x,
    output logic signed [19:0] new_pos_y,
    output logic signed [19:0] new_vel_x,
    output logic signed [19:0] new_vel_y,
    output logic               hit_wall,
    output logic               last_out
);

    logic signed [23:0] accel_x_reg;
    logic signed [23:0] accel_y_reg;
    logic [15:0]        time_step_reg;
    logic [16:0]        restitution_reg;
    logic [16:0]        tangent_reg;
    logic [15:0]        part_rad_reg;
    logic [15:0]        cont_rad_reg;
    logic [31:0]        cont_sq_reg;

    logic [N_STG-1:0]   valid_reg;
    item_t              pipe_reg [N_STG];
    item_t              in_item;
    logic               adv;

    logic signed [16:0] dt_s;
    logic signed [17:0] rest_s;
    logic signed [17:0] tk_s;
    logic signed [21:0] lo_s;
    logic signed [21:0] hi_s;
    logic signed [16:0] cr_s;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_x_reg     <= '0;
            accel_y_reg     <= '0;
            time_step_reg   <= TIME_STEP_RST;
            restitution_reg <= RESTITUTION_RST;
            tangent_reg     <= TANGENT_RST;
            part_rad_reg    <= PART_RAD_RST;
            cont_rad_reg    <= CONT_RAD_RST;
            cont_sq_reg     <= CONT_SQ_RST;
        end
        else
        begin
            cont_sq_reg <= 32'(cont_rad_reg) * 32'(cont_rad_reg);
            if (cfg_valid)
            begin
                case (cfg_addr)
                    REG_ACCEL_X:     accel_x_reg     <= cfg_data;
                    REG_ACCEL_Y:     accel_y_reg     <= cfg_data;
                    REG_TIME_STEP:   time_step_reg   <= cfg_data[15:0];
                    REG_RESTITUTION: restitution_reg <= cfg_data[16:0];
                    REG_TANGENT:     tangent_reg     <= cfg_data[16:0];
                    REG_PART_RAD:    part_rad_reg    <= cfg_data[15:0];
                    REG_CONT_RAD:    cont_rad_reg    <= cfg_data[15:0];
                    default:         ;
                endcase
            end
        end
    end

    assign dt_s   = signed'({1'b0, time_step_reg});
    assign rest_s = signed'({1'b0, restitution_reg});
    assign tk_s   = signed'({1'b0, tangent_reg});
    assign lo_s   = signed'({6'b0, part_rad_reg});
    assign hi_s   = ONE_FX - lo_s;
    assign cr_s   = signed'({1'b0, cont_rad_reg});

    // whole pipe advances unless the output stage holds an untaken item
    assign adv      = !valid_reg[N_STG-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[N_STG-2:0], in_valid};
    end

    always_comb
    begin
        in_item      = '0;
        in_item.px   = 22'(pos_x);
        in_item.py   = 22'(pos_y);
        in_item.vx   = vel_x;
        in_item.vy   = vel_y;
        in_item.last = last_item;
    end

    for (genvar s = 0; s < N_STG; s++)
    begin : g_stg
        item_t prv;
        item_t nxt;

        if (s == 0)
        begin : g_src_in
            assign prv = in_item;
        end
        else
        begin : g_src_pipe
            assign prv = pipe_reg[s-1];
        end

        if (s == 0)
        begin : g_acc_mul
            always_comb
            begin
                nxt    = prv;
                nxt.ma = 44'(accel_x_reg) * 44'(dt_s);
                nxt.mb = 44'(accel_y_reg) * 44'(dt_s);
            end
        end
        else if (s == 1)
        begin : g_vel
            always_comb
            begin
                nxt    = prv;
                nxt.vx = sat20(44'(prv.vx) + rescale(prv.ma));
                nxt.vy = sat20(44'(prv.vy) + rescale(prv.mb));
            end
        end
        else if (s == 2)
        begin : g_pos_mul
            always_comb
            begin
                nxt    = prv;
                nxt.ma = 44'(prv.vx) * 44'(dt_s);
                nxt.mb = 44'(prv.vy) * 44'(dt_s);
            end
        end
        else if (s == 3)
        begin : g_pos
            always_comb
            begin
                nxt    = prv;
                nxt.px = prv.px + 22'(rescale(prv.ma));
                nxt.py = prv.py + 22'(rescale(prv.mb));
            end
        end
        else if (s == 4)
        begin : g_clamp
            // lower bound first, so an inverted box resolves the same way
            always_comb
            begin
                nxt = prv;
                if (prv.px < lo_s)
                    nxt.px = lo_s;
                else if (prv.px > hi_s)
                    nxt.px = hi_s;
                if (prv.py < lo_s)
                    nxt.py = lo_s;
                else if (prv.py > hi_s)
                    nxt.py = hi_s;
            end
        end
        else if (s == 5)
        begin : g_delta
            always_comb
            begin
                nxt    = prv;
                nxt.dx = 17'(prv.px - HALF_P);
                nxt.dy = 17'(prv.py - HALF_P);
            end
        end
        else if (s == 6)
        begin : g_sq_mul
            always_comb
            begin
                nxt    = prv;
                nxt.ma = 44'(prv.dx) * 44'(prv.dx);
                nxt.mb = 44'(prv.dy) * 44'(prv.dy);
            end
        end
        else if (s == 7)
        begin : g_dist
            logic [16:0] mag_x;
            logic [16:0] mag_y;
            logic [31:0] d2_v;
            always_comb
            begin
                mag_x      = prv.dx[16] ? 17'(-prv.dx) : 17'(prv.dx);
                mag_y      = prv.dy[16] ? 17'(-prv.dy) : 17'(prv.dy);
                d2_v       = 32'(prv.ma + prv.mb);
                nxt        = prv;
                nxt.d2     = d2_v;
                nxt.hit    = d2_v > cont_sq_reg;
                nxt.srem   = '0;
                nxt.root   = '0;
                nxt.ax_div = {mag_x[15:0], 16'h0000};
                nxt.ay_div = {mag_y[15:0], 16'h0000};
            end
        end
        else if (s >= SQ0 && s < DV0)
        begin : g_sqrt
            // one result bit per stage, two radicand bits brought down
            logic [18:0] rem_s;
            logic [18:0] trial;
            always_comb
            begin
                rem_s  = {prv.srem[16:0], prv.d2[31:30]};
                trial  = {1'b0, prv.root, 2'b01};
                nxt    = prv;
                nxt.d2 = {prv.d2[29:0], 2'b00};
                if (rem_s >= trial)
                begin
                    nxt.srem = rem_s - trial;
                    nxt.root = {prv.root[14:0], 1'b1};
                end
                else
                begin
                    nxt.srem = rem_s;
                    nxt.root = {prv.root[14:0], 1'b0};
                end
            end
        end
        else if (s >= DV0 && s < B1)
        begin : g_div
            localparam int J = s - DV0;
            logic [16:0] rxp;
            logic [16:0] ryp;
            logic [16:0] qxp;
            logic [16:0] qyp;
            logic [16:0] rxs;
            logic [16:0] rys;
            logic [16:0] dv;
            always_comb
            begin
                if (J == 0)
                begin
                    rxp = {2'b00, prv.ax_div[31:17]};
                    ryp = {2'b00, prv.ay_div[31:17]};
                    qxp = '0;
                    qyp = '0;
                end
                else
                begin
                    rxp = prv.remx;
                    ryp = prv.remy;
                    qxp = prv.qx;
                    qyp = prv.qy;
                end
                dv  = {1'b0, prv.root};
                rxs = {rxp[15:0], prv.ax_div[16-J]};
                rys = {ryp[15:0], prv.ay_div[16-J]};
                nxt = prv;
                if (rxs >= dv)
                begin
                    nxt.remx = rxs - dv;
                    nxt.qx   = {qxp[15:0], 1'b1};
                end
                else
                begin
                    nxt.remx = rxs;
                    nxt.qx   = {qxp[15:0], 1'b0};
                end
                if (rys >= dv)
                begin
                    nxt.remy = rys - dv;
                    nxt.qy   = {qyp[15:0], 1'b1};
                end
                else
                begin
                    nxt.remy = rys;
                    nxt.qy   = {qyp[15:0], 1'b0};
                end
            end
        end
        else if (s == B1)
        begin : g_normal
            always_comb
            begin
                nxt     = prv;
                nxt.nx  = prv.dx[16] ? -signed'({1'b0, prv.qx}) : signed'({1'b0, prv.qx});
                nxt.ny  = prv.dy[16] ? -signed'({1'b0, prv.qy}) : signed'({1'b0, prv.qy});
                nxt.pen = cr_s - signed'({1'b0, prv.root});
            end
        end
        else if (s == B1 + 1)
        begin : g_norm_mul
            always_comb
            begin
                nxt    = prv;
                nxt.ma = 44'(prv.nx) * 44'(prv.pen);
                nxt.mb = 44'(prv.ny) * 44'(prv.pen);
                nxt.mc = 44'(prv.vx) * 44'(prv.nx);
                nxt.md = 44'(prv.vy) * 44'(prv.ny);
            end
        end
        else if (s == B1 + 2)
        begin : g_push
            // move the particle back onto the rim
            always_comb
            begin
                nxt    = prv;
                nxt.px = prv.hit ? prv.px + 22'(rescale(prv.ma)) : prv.px;
                nxt.py = prv.hit ? prv.py + 22'(rescale(prv.mb)) : prv.py;
                nxt.mc = prv.mc + prv.md;
            end
        end
        else if (s == B1 + 3)
        begin : g_vn
            always_comb
            begin
                nxt    = prv;
                nxt.vn = 22'(rescale(prv.mc));
            end
        end
        else if (s == B1 + 4)
        begin : g_vn_mul
            always_comb
            begin
                nxt    = prv;
                nxt.ma = 44'(prv.vn) * 44'(prv.nx);
                nxt.mb = 44'(prv.vn) * 44'(prv.ny);
            end
        end
        else if (s == B1 + 5)
        begin : g_split
            logic signed [22:0] vxn_v;
            logic signed [22:0] vyn_v;
            always_comb
            begin
                vxn_v   = 23'(rescale(prv.ma));
                vyn_v   = 23'(rescale(prv.mb));
                nxt     = prv;
                nxt.vxn = vxn_v;
                nxt.vyn = vyn_v;
                nxt.vxt = 23'(prv.vx) - vxn_v;
                nxt.vyt = 23'(prv.vy) - vyn_v;
            end
        end
        else if (s == B1 + 6)
        begin : g_resp_mul
            always_comb
            begin
                nxt    = prv;
                nxt.ma = -(44'(rest_s) * 44'(prv.vxn));
                nxt.mb = 44'(tk_s) * 44'(prv.vxt);
                nxt.mc = -(44'(rest_s) * 44'(prv.vyn));
                nxt.md = 44'(tk_s) * 44'(prv.vyt);
            end
        end
        else
        begin : g_out
            always_comb
            begin
                nxt    = prv;
                nxt.px = 22'(sat20(44'(prv.px)));
                nxt.py = 22'(sat20(44'(prv.py)));
                if (prv.hit)
                begin
                    nxt.vx = sat20(rescale(prv.ma) + rescale(prv.mb));
                    nxt.vy = sat20(rescale(prv.mc) + rescale(prv.md));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                pipe_reg[s] <= nxt;
        end
    end

    assign out_valid = valid_reg[N_STG-1];
    assign new_pos_x = pipe_reg[N_STG-1].px[19:0];
    assign new_pos_y = pipe_reg[N_STG-1].py[19:0];
    assign new_vel_x = pipe_reg[N_STG-1].vx;
    assign new_vel_y = pipe_reg[N_STG-1].vy;
    assign hit_wall  = pipe_reg[N_STG-1].hit;
    assign last_out  = pipe_reg[N_STG-1].last;

endmodule
